>>> rtl/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int STATUS_WIDTH    = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_UNDER = 2'd1,
        STATUS_OVER  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic fill;
    } cmd_t;

    typedef struct packed {
        logic fetch_needed;
        logic result_free;
    } dp_status_t;

endpackage : mts_pkg
`default_nettype wire

>>> rtl/min_tracking_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack
// A stack of signed values that reports its top, its running minimum and its
// fill level after every push or pop.
// ----------------------------------------------------------------------------
// Each item is a push or a pop, and each gives one result item. A push or any
// failed operation is captured in the idle state and executed in the execute
// state, which registers its result; the block then returns to idle and can
// take the next item. A pop that leaves values on the stack also passes
// through the fetch state, because the new stack tops are read back from the
// registered read ports of the two stack memories. The block takes one item at
// a time, but it accepts the next item while the previous result is still
// waiting at the output register. A stalled result holds back only the
// execution of the following item. A pop on an empty stack reports underflow
// and a push on a full stack reports overflow and is dropped; neither changes
// the stack. Stack memories need no clearing after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = mts_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  mode,
    input  wire logic signed [VALUE_WIDTH-1:0]         push_value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mts_pkg::OUT_WIDTH-1:0]       popped_value,
    output logic signed [mts_pkg::OUT_WIDTH-1:0]       top_value,
    output logic signed [mts_pkg::OUT_WIDTH-1:0]       min_value,
    output logic                                       is_empty,
    output logic [$clog2(STACK_DEPTH+1)-1:0]           item_count,
    output logic [mts_pkg::STATUS_WIDTH-1:0]           status
);

    import mts_pkg::*;

    cmd_t       cmd;
    dp_status_t stat;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mts_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .top_value    (top_value),
        .min_value    (min_value),
        .is_empty     (is_empty),
        .item_count   (item_count),
        .status       (status)
    );

endmodule : min_tracking_stack_top
`default_nettype wire

>>> rtl/mts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : mts_ram
`default_nettype wire

>>> rtl/mts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack datapath
// Stack counts, cached stack tops, the two stack memories and the result
// register.
// ----------------------------------------------------------------------------
module mts_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mts_pkg::cmd_t                         cmd,
    output mts_pkg::dp_status_t                        stat,
    input  wire logic                                  mode,
    input  wire logic signed [VALUE_WIDTH-1:0]         push_value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mts_pkg::OUT_WIDTH-1:0]       popped_value,
    output logic signed [mts_pkg::OUT_WIDTH-1:0]       top_value,
    output logic signed [mts_pkg::OUT_WIDTH-1:0]       min_value,
    output logic                                       is_empty,
    output logic [$clog2(STACK_DEPTH+1)-1:0]           item_count,
    output logic [mts_pkg::STATUS_WIDTH-1:0]           status
);

    import mts_pkg::*;

    localparam int AddrWidth  = $clog2(STACK_DEPTH);
    localparam int CountWidth = $clog2(STACK_DEPTH + 1);

    logic                          mode_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic [CountWidth-1:0]         count_reg, count_next;
    logic [CountWidth-1:0]         mcount_reg, mcount_next;
    logic signed [VALUE_WIDTH-1:0] top_reg, top_next;
    logic signed [VALUE_WIDTH-1:0] mtop_reg, mtop_next;
    logic                          valid_reg, valid_next;
    logic signed [OUT_WIDTH-1:0]   popped_reg, popped_next;
    logic signed [OUT_WIDTH-1:0]   rtop_reg, rtop_next;
    logic signed [OUT_WIDTH-1:0]   rmin_reg, rmin_next;
    logic [CountWidth-1:0]         rcount_reg, rcount_next;
    status_t                       rstatus_reg, rstatus_next;

    logic                          is_pop, under, over, pop_ok, push_ok;
    logic                          min_push, min_pop, fetch_needed, taken;
    logic [CountWidth-1:0]         count_dec, count_dec2, mcount_dec, mcount_dec2;
    logic [CountWidth-1:0]         exec_count, exec_mcount;
    logic signed [VALUE_WIDTH-1:0] exec_top, exec_mtop;
    logic [AddrWidth-1:0]          val_rd_addr, min_rd_addr;
    logic [VALUE_WIDTH-1:0]        val_rd_data, min_rd_data;

    assign is_pop   = (mode_reg == MODE_POP);
    assign under    = is_pop && (count_reg == '0);
    assign over     = !is_pop && (count_reg == CountWidth'(STACK_DEPTH));
    assign pop_ok   = is_pop && !under;
    assign push_ok  = !is_pop && !over;
    assign min_push = push_ok && ((mcount_reg == '0) || (value_reg <= mtop_reg));
    assign min_pop  = pop_ok && (mcount_reg != '0) && (top_reg == mtop_reg);

    assign count_dec    = count_reg - CountWidth'(1);
    assign count_dec2   = count_reg - CountWidth'(2);
    assign mcount_dec   = mcount_reg - CountWidth'(1);
    assign mcount_dec2  = mcount_reg - CountWidth'(2);
    assign fetch_needed = pop_ok && (count_reg != CountWidth'(1));

    assign val_rd_addr = count_dec2[AddrWidth-1:0];
    assign min_rd_addr = min_pop ? mcount_dec2[AddrWidth-1:0] : mcount_dec[AddrWidth-1:0];

    assign taken            = valid_reg && !out_stall;
    assign stat.fetch_needed = fetch_needed;
    assign stat.result_free  = !valid_reg || !out_stall;

    mts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && push_ok),
        .wr_addr (count_reg[AddrWidth-1:0]),
        .wr_data (value_reg),
        .rd_en   (cmd.exec && fetch_needed),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    mts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && min_push),
        .wr_addr (mcount_reg[AddrWidth-1:0]),
        .wr_data (value_reg),
        .rd_en   (cmd.exec && fetch_needed),
        .rd_addr (min_rd_addr),
        .rd_data (min_rd_data)
    );

    always_comb
    begin
        exec_count  = count_reg;
        exec_mcount = mcount_reg;
        exec_top    = top_reg;
        exec_mtop   = mtop_reg;
        if (push_ok)
        begin
            exec_count = count_reg + CountWidth'(1);
            exec_top   = value_reg;
            if (min_push)
            begin
                exec_mcount = mcount_reg + CountWidth'(1);
                exec_mtop   = value_reg;
            end
        end
        else if (pop_ok)
        begin
            exec_count = count_dec;
            if (min_pop)
            begin
                exec_mcount = mcount_dec;
            end
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        mcount_next  = mcount_reg;
        top_next     = top_reg;
        mtop_next    = mtop_reg;
        valid_next   = valid_reg && !taken;
        popped_next  = popped_reg;
        rtop_next    = rtop_reg;
        rmin_next    = rmin_reg;
        rcount_next  = rcount_reg;
        rstatus_next = rstatus_reg;
        if (cmd.exec)
        begin
            count_next   = exec_count;
            mcount_next  = exec_mcount;
            top_next     = exec_top;
            mtop_next    = exec_mtop;
            popped_next  = pop_ok ? OUT_WIDTH'(top_reg) : '0;
            rtop_next    = (exec_count == '0) ? '0 : OUT_WIDTH'(exec_top);
            rmin_next    = (exec_count == '0) ? '0 : OUT_WIDTH'(exec_mtop);
            rcount_next  = exec_count;
            rstatus_next = under ? STATUS_UNDER : (over ? STATUS_OVER : STATUS_OK);
            valid_next   = !fetch_needed;
        end
        if (cmd.fill)
        begin
            top_next   = val_rd_data;
            mtop_next  = min_rd_data;
            rtop_next  = OUT_WIDTH'($signed(val_rd_data));
            rmin_next  = OUT_WIDTH'($signed(min_rd_data));
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mcount_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            mcount_reg <= mcount_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg  <= mode;
            value_reg <= push_value;
        end
        top_reg     <= top_next;
        mtop_reg    <= mtop_next;
        popped_reg  <= popped_next;
        rtop_reg    <= rtop_next;
        rmin_reg    <= rmin_next;
        rcount_reg  <= rcount_next;
        rstatus_reg <= rstatus_next;
    end

    assign out_valid    = valid_reg;
    assign popped_value = popped_reg;
    assign top_value    = rtop_reg;
    assign min_value    = rmin_reg;
    assign is_empty     = (rcount_reg == '0);
    assign item_count   = rcount_reg;
    assign status       = rstatus_reg;

endmodule : mts_dp
`default_nettype wire

>>> rtl/mts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack controller
// Sequences input capture, execution and the refill of the stack tops.
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire mts_pkg::dp_status_t stat,
    output mts_pkg::cmd_t            cmd
);

    import mts_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.result_free)
                begin
                    state_next = stat.fetch_needed ? ST_FETCH : ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.latch_in = 1'b0;
        cmd.exec     = 1'b0;
        cmd.fill     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = stat.result_free;
            end
            ST_FETCH:
            begin
                cmd.fill = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : mts_ctrl
`default_nettype wire
